### design/sdr_pkg.sv
// Package for the sector record deframer: constants, codes and shared types.
`timescale 1ns / 1ps

package sdr_pkg;

    // Sector geometry
    localparam int SECTOR_SIZE = 256;
    localparam int SL_W         = $clog2(SECTOR_SIZE + 1);
    localparam int LEN_W        = 8;
    localparam int CMP_W        = (SL_W > LEN_W) ? SL_W : LEN_W;
    localparam int CNT_W        = 16;

    localparam logic [SL_W-1:0]  SECTOR_INIT = SL_W'(SECTOR_SIZE);
    localparam logic [LEN_W-1:0] SKIP_MARK   = 8'hFF;
    localparam logic [LEN_W-1:0] RECLEN_INIT = 8'd80;

    // Input item kinds
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_EOF   = 2'd1;
    localparam logic [1:0] KIND_START = 2'd2;

    // Completion status codes
    localparam logic [1:0] ST_COMPLETE = 2'd0;
    localparam logic [1:0] ST_TRUNC    = 2'd1;
    localparam logic [1:0] ST_CORRUPT  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_VARIABLE_MODE = 2'd0;
    localparam logic [1:0] CFG_RECORD_LENGTH = 2'd1;
    localparam logic [1:0] CFG_RECORD_TOTAL  = 2'd2;

    // Parser phase
    typedef enum logic [2:0] {
        PH_START,
        PH_PAYLOAD,
        PH_EXCESS,
        PH_SKIP,
        PH_DONE
    } phase_t;

    // One result item
    typedef struct packed {
        logic             data_valid;
        logic [LEN_W-1:0] out_byte;
        logic [LEN_W-1:0] byte_offset;
        logic [CNT_W-1:0] record_index;
        logic             record_end;
        logic [LEN_W-1:0] record_len;
        logic             done_res;
        logic [1:0]       status;
        logic [CNT_W-1:0] record_count;
    } res_t;

endpackage

### design/sector_record_deframer.sv
// Top level of the sector record deframer: parser state and result register.
`timescale 1ns / 1ps

// Takes one file byte (or an end-of-file or start item) per clock and gives at
// most one result per item, the cycle after the transfer, from a single result
// register. Sustained rate is one item per clock: all parsing of an item is one
// pass of logic between the parser state registers and the result register, so
// a new item is taken every cycle that in_stall is low. in_stall rises only
// while a result is held in the result register and out_stall is high. There
// is no memory and no clearing pass; the block accepts items straight after reset.
// Configuration registers are read live and are to be written only while idle.
module sector_record_deframer (
    input  logic                     clk,
    input  logic                     rst_n,
    // configuration write port
    input  logic                     cfg_we,
    input  logic [1:0]               cfg_index,
    input  logic [15:0]              cfg_data,
    // input channel
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               kind,
    input  logic [7:0]               data_byte,
    // output channel
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     data_valid,
    output logic [7:0]               out_byte,
    output logic [7:0]               byte_offset,
    output logic [15:0]              record_index,
    output logic                     record_end,
    output logic [7:0]               record_len,
    output logic                     done_res,
    output logic [1:0]               status,
    output logic [15:0]              record_count
);
    import sdr_pkg::*;

    // configuration
    logic             variable_mode_reg;
    logic [LEN_W-1:0] record_length_reg;
    logic [CNT_W-1:0] record_total_reg;

    // parser state
    phase_t           phase_reg, phase_next;
    logic [SL_W-1:0]  sector_left_reg, sector_left_next;
    logic [LEN_W-1:0] payload_left_reg, payload_left_next;
    logic [LEN_W-1:0] excess_left_reg, excess_left_next;
    logic [LEN_W-1:0] stored_len_reg, stored_len_next;
    logic [LEN_W-1:0] offset_reg, offset_next;
    logic [CNT_W-1:0] sectors_rem_reg, sectors_rem_next;
    logic [CNT_W-1:0] records_done_reg, records_done_next;

    // result register
    logic             out_valid_reg;
    res_t             res_reg;
    res_t             res_next;
    logic             res_fire;

    logic             in_fire;
    logic             deliver_now;
    logic [LEN_W-1:0] fixed_len;
    logic [SL_W-1:0]  sl_dec;
    logic [SL_W-1:0]  sl_fix;
    logic [CNT_W-1:0] sr_dec;

    // Handshake: stall only while a held result is not being taken
    assign in_stall = out_valid_reg & out_stall;
    assign in_fire  = in_valid & ~in_stall;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            variable_mode_reg <= 1'b0;
            record_length_reg <= RECLEN_INIT;
            record_total_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_VARIABLE_MODE: variable_mode_reg <= cfg_data[0];
                CFG_RECORD_LENGTH: record_length_reg <= cfg_data[LEN_W-1:0];
                CFG_RECORD_TOTAL:  record_total_reg  <= cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Next state and result for the item at the input
    always_comb
    begin
        phase_next        = phase_reg;
        sector_left_next  = sector_left_reg;
        payload_left_next = payload_left_reg;
        excess_left_next  = excess_left_reg;
        stored_len_next   = stored_len_reg;
        offset_next       = offset_reg;
        sectors_rem_next  = sectors_rem_reg;
        records_done_next = records_done_reg;
        res_next          = '0;
        res_fire          = 1'b0;
        deliver_now       = 1'b0;

        fixed_len = (record_length_reg == '0) ? LEN_W'(1) : record_length_reg;
        sl_dec    = sector_left_reg - SL_W'(1);
        sl_fix    = (sector_left_reg == '0) ? SECTOR_INIT : sector_left_reg;
        sr_dec    = sectors_rem_reg - CNT_W'(1);

        if (in_fire)
        begin
            if (kind == KIND_START)
            begin
                // reload everything for a new file
                phase_next        = PH_START;
                sector_left_next  = SECTOR_INIT;
                payload_left_next = '0;
                excess_left_next  = '0;
                stored_len_next   = '0;
                offset_next       = '0;
                sectors_rem_next  = record_total_reg;
                records_done_next = '0;
                if (!variable_mode_reg && record_total_reg == '0)
                begin
                    phase_next        = PH_DONE;
                    res_fire          = 1'b1;
                    res_next.done_res = 1'b1;
                    res_next.status   = ST_COMPLETE;
                end
            end
            else if (kind == KIND_EOF && phase_reg != PH_DONE)
            begin
                phase_next        = PH_DONE;
                res_fire          = 1'b1;
                res_next.done_res = 1'b1;
                if (phase_reg == PH_START && !variable_mode_reg
                    && records_done_reg >= record_total_reg)
                    res_next.status = ST_COMPLETE;
                else
                    res_next.status = ST_TRUNC;
            end
            else if (kind == KIND_DATA)
            begin
                unique case (phase_reg)
                    PH_DONE: ;
                    PH_PAYLOAD:
                    begin
                        deliver_now = 1'b1;
                    end
                    PH_EXCESS:
                    begin
                        if (excess_left_reg != '0)
                            excess_left_next = excess_left_reg - LEN_W'(1);
                        if (excess_left_next == '0)
                            phase_next = PH_START;
                    end
                    PH_SKIP:
                    begin
                        if (sector_left_reg != '0)
                            sector_left_next = sl_dec;
                        if (sector_left_next == '0)
                        begin
                            sector_left_next = SECTOR_INIT;
                            phase_next       = PH_START;
                        end
                    end
                    PH_START:
                    begin
                        if (variable_mode_reg)
                        begin
                            // length byte of a variable record
                            if (sector_left_reg == '0)
                            begin
                                phase_next        = PH_DONE;
                                res_fire          = 1'b1;
                                res_next.done_res = 1'b1;
                                res_next.status   = ST_CORRUPT;
                            end
                            else if (data_byte == SKIP_MARK)
                            begin
                                sectors_rem_next = sr_dec;
                                sector_left_next = sl_dec;
                                if (sr_dec == '0)
                                begin
                                    phase_next        = PH_DONE;
                                    res_fire          = 1'b1;
                                    res_next.done_res = 1'b1;
                                    res_next.status   = ST_COMPLETE;
                                end
                                else if (sl_dec == '0)
                                    sector_left_next = SECTOR_INIT;
                                else
                                    phase_next = PH_SKIP;
                            end
                            else if (CMP_W'(sl_dec) < CMP_W'(data_byte))
                            begin
                                sector_left_next  = sl_dec;
                                phase_next        = PH_DONE;
                                res_fire          = 1'b1;
                                res_next.done_res = 1'b1;
                                res_next.status   = ST_CORRUPT;
                            end
                            else
                            begin
                                sector_left_next =
                                    SL_W'(CMP_W'(sl_dec) - CMP_W'(data_byte));
                                if (data_byte > record_length_reg)
                                begin
                                    stored_len_next  = record_length_reg;
                                    excess_left_next = data_byte - record_length_reg;
                                end
                                else
                                begin
                                    stored_len_next  = data_byte;
                                    excess_left_next = '0;
                                end
                                offset_next       = '0;
                                payload_left_next = stored_len_next;
                                if (stored_len_next == '0)
                                begin
                                    // empty record ends on its length byte
                                    records_done_next     = records_done_reg + CNT_W'(1);
                                    phase_next            = (excess_left_next != '0) ?
                                                            PH_EXCESS : PH_START;
                                    res_fire              = 1'b1;
                                    res_next.record_index = records_done_reg;
                                    res_next.record_end   = 1'b1;
                                end
                                else
                                    phase_next = PH_PAYLOAD;
                            end
                        end
                        else
                        begin
                            // first byte of a fixed record
                            if (records_done_reg >= record_total_reg)
                            begin
                                phase_next        = PH_DONE;
                                res_fire          = 1'b1;
                                res_next.done_res = 1'b1;
                                res_next.status   = ST_COMPLETE;
                            end
                            else if (CMP_W'(sl_fix) < CMP_W'(fixed_len))
                            begin
                                // record does not fit: skip rest of sector
                                sector_left_next = sl_fix - SL_W'(1);
                                if (sector_left_next == '0)
                                    sector_left_next = SECTOR_INIT;
                                else
                                    phase_next = PH_SKIP;
                            end
                            else
                            begin
                                sector_left_next  =
                                    SL_W'(CMP_W'(sl_fix) - CMP_W'(fixed_len));
                                stored_len_next   = fixed_len;
                                payload_left_next = fixed_len;
                                excess_left_next  = '0;
                                offset_next       = '0;
                                phase_next        = PH_PAYLOAD;
                                deliver_now       = 1'b1;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end

        // Payload byte delivery, from the state as updated above
        if (deliver_now)
        begin
            res_fire              = 1'b1;
            res_next.data_valid   = 1'b1;
            res_next.out_byte     = data_byte;
            res_next.byte_offset  = offset_next;
            res_next.record_index = records_done_next;
            res_next.status       = ST_COMPLETE;
            offset_next           = offset_next + LEN_W'(1);
            if (payload_left_next != '0)
                payload_left_next = payload_left_next - LEN_W'(1);
            if (payload_left_next == '0)
            begin
                res_next.record_end = 1'b1;
                res_next.record_len = stored_len_next;
                records_done_next   = records_done_next + CNT_W'(1);
                phase_next          = (excess_left_next != '0) ? PH_EXCESS : PH_START;
                if (!variable_mode_reg && records_done_next >= record_total_reg)
                begin
                    res_next.done_res = 1'b1;
                    phase_next        = PH_DONE;
                end
            end
        end

        res_next.record_count = records_done_next;
    end

    // Parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_START;
            sector_left_reg  <= SECTOR_INIT;
            payload_left_reg <= '0;
            excess_left_reg  <= '0;
            stored_len_reg   <= '0;
            offset_reg       <= '0;
            sectors_rem_reg  <= '0;
            records_done_reg <= '0;
        end
        else
        begin
            phase_reg        <= phase_next;
            sector_left_reg  <= sector_left_next;
            payload_left_reg <= payload_left_next;
            excess_left_reg  <= excess_left_next;
            stored_len_reg   <= stored_len_next;
            offset_reg       <= offset_next;
            sectors_rem_reg  <= sectors_rem_next;
            records_done_reg <= records_done_next;
        end
    end

    // Result register: refilled whenever it is free or being taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (!in_stall)
            out_valid_reg <= in_fire & res_fire;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && res_fire)
            res_reg <= res_next;
    end

    // Output ports
    assign out_valid    = out_valid_reg;
    assign data_valid   = res_reg.data_valid;
    assign out_byte     = res_reg.out_byte;
    assign byte_offset  = res_reg.byte_offset;
    assign record_index = res_reg.record_index;
    assign record_end   = res_reg.record_end;
    assign record_len   = res_reg.record_len;
    assign done_res     = res_reg.done_res;
    assign status       = res_reg.status;
    assign record_count = res_reg.record_count;

endmodule

### sim/deframer_scoreboard.sv
// Scoreboard for the sector record deframer: predicts each result and compares it.
`timescale 1ns / 1ps

module deframer_scoreboard
    import sdr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [7:0]  data_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  res_t        seen,
    output int          errors,
    output int          waiting
);

    // Shadow copy of the configuration registers
    logic             var_mode;
    logic [7:0]       rec_length;
    logic [15:0]      rec_total;

    // Parser state of the prediction
    phase_t           ph;
    logic [SL_W-1:0]  sec_left;
    logic [7:0]       pay_left;
    logic [7:0]       exc_left;
    logic [7:0]       stored_len;
    logic [7:0]       rec_off;
    logic [15:0]      sectors_left;
    logic [15:0]      rec_done;

    res_t             expected_q[$];
    int               fail_count;

    function automatic void restart_file();
        ph           = PH_START;
        sec_left     = SECTOR_INIT;
        pay_left     = '0;
        exc_left     = '0;
        stored_len   = '0;
        rec_off      = '0;
        sectors_left = rec_total;
        rec_done     = '0;
    endfunction

    function automatic res_t make_res(logic dv, logic [7:0] b, logic [7:0] off,
                                      logic [15:0] idx, logic fin, logic [7:0] len,
                                      logic dn, logic [1:0] st);
        res_t r;
        r.data_valid   = dv;
        r.out_byte     = b;
        r.byte_offset  = off;
        r.record_index = idx;
        r.record_end   = fin;
        r.record_len   = len;
        r.done_res     = dn;
        r.status       = st;
        r.record_count = rec_done;
        return r;
    endfunction

    function automatic bit end_file(logic [1:0] st, output res_t r);
        ph = PH_DONE;
        r  = make_res(1'b0, '0, '0, '0, 1'b0, '0, 1'b1, st);
        return 1'b1;
    endfunction

    // One payload byte of the current record
    function automatic bit take_payload(logic [7:0] b, output res_t r);
        logic [15:0] idx;
        logic [7:0]  off;
        logic        fin;
        logic        dn;
        idx = rec_done;
        off = rec_off;
        fin = 1'b0;
        dn  = 1'b0;
        rec_off++;
        if (pay_left != 0)
            pay_left--;
        if (pay_left == 0)
        begin
            fin = 1'b1;
            rec_done++;
            ph = (exc_left != 0) ? PH_EXCESS : PH_START;
            if (!var_mode && rec_done >= rec_total)
            begin
                dn = 1'b1;
                ph = PH_DONE;
            end
        end
        r = make_res(1'b1, b, off, idx, fin, fin ? stored_len : 8'd0, dn, ST_COMPLETE);
        return 1'b1;
    endfunction

    // Advance the predicted parser by one transfer; returns 1 when a result is due
    function automatic bit parse_item(logic [1:0] k, logic [7:0] b, output res_t r);
        logic [15:0] idx;
        logic [7:0]  flen;
        r = '0;
        if (k == KIND_START)
        begin
            restart_file();
            if (!var_mode && rec_total == 0)
                return end_file(ST_COMPLETE, r);
            return 1'b0;
        end
        if (!(k inside {KIND_DATA, KIND_EOF}) || ph == PH_DONE)
            return 1'b0;
        if (k == KIND_EOF)
        begin
            if (ph == PH_START && !var_mode && rec_done >= rec_total)
                return end_file(ST_COMPLETE, r);
            return end_file(ST_TRUNC, r);
        end

        case (ph)
            PH_PAYLOAD:
                return take_payload(b, r);
            PH_EXCESS:
            begin
                if (exc_left != 0)
                    exc_left--;
                if (exc_left == 0)
                    ph = PH_START;
                return 1'b0;
            end
            PH_SKIP:
            begin
                if (sec_left != 0)
                    sec_left--;
                if (sec_left == 0)
                begin
                    sec_left = SECTOR_INIT;
                    ph       = PH_START;
                end
                return 1'b0;
            end
            default: ;
        endcase

        // Record start, variable mode: length byte or end-of-sector mark
        if (var_mode)
        begin
            if (sec_left == 0)
                return end_file(ST_CORRUPT, r);
            sec_left--;
            if (b == SKIP_MARK)
            begin
                sectors_left--;
                if (sectors_left == 0)
                    return end_file(ST_COMPLETE, r);
                if (sec_left == 0)
                    sec_left = SECTOR_INIT;
                else
                    ph = PH_SKIP;
                return 1'b0;
            end
            if (sec_left < b)
                return end_file(ST_CORRUPT, r);
            sec_left -= b;
            if (b > rec_length)
            begin
                stored_len = rec_length;
                exc_left   = b - rec_length;
            end
            else
            begin
                stored_len = b;
                exc_left   = '0;
            end
            rec_off  = '0;
            pay_left = stored_len;
            if (stored_len == 0)
            begin
                idx = rec_done;
                rec_done++;
                ph = (exc_left != 0) ? PH_EXCESS : PH_START;
                r  = make_res(1'b0, '0, '0, idx, 1'b1, '0, 1'b0, ST_COMPLETE);
                return 1'b1;
            end
            ph = PH_PAYLOAD;
            return 1'b0;
        end

        // Record start, fixed mode: a length of zero reads as one
        flen = (rec_length != 0) ? rec_length : 8'd1;
        if (rec_done >= rec_total)
            return end_file(ST_COMPLETE, r);
        if (sec_left == 0)
            sec_left = SECTOR_INIT;
        if (sec_left < flen)
        begin
            sec_left--;
            if (sec_left == 0)
                sec_left = SECTOR_INIT;
            else
                ph = PH_SKIP;
            return 1'b0;
        end
        sec_left  -= flen;
        stored_len = flen;
        pay_left   = flen;
        exc_left   = '0;
        rec_off    = '0;
        ph         = PH_PAYLOAD;
        return take_payload(b, r);
    endfunction

    function automatic int score_field(string name, logic [15:0] want, logic [15:0] got);
        if (got === want)
            return 0;
        $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
        return 1;
    endfunction

    // Track configuration and transfers, compare results in order
    always @(posedge clk or negedge rst_n)
    begin
        res_t predicted;
        res_t want;
        if (!rst_n)
        begin
            var_mode   = 1'b0;
            rec_length = RECLEN_INIT;
            rec_total  = '0;
            restart_file();
            expected_q.delete();
            fail_count = 0;
            errors    <= 0;
            waiting   <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_VARIABLE_MODE: var_mode   = cfg_data[0];
                    CFG_RECORD_LENGTH: rec_length = cfg_data[7:0];
                    CFG_RECORD_TOTAL:  rec_total  = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                if (parse_item(kind, data_byte, predicted))
                    expected_q.push_back(predicted);
            end
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t ns: result with none expected, actual %h", $time, seen);
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    fail_count += score_field("data_valid", 16'(want.data_valid),
                                              16'(seen.data_valid))
                        + score_field("out_byte", 16'(want.out_byte), 16'(seen.out_byte))
                        + score_field("byte_offset", 16'(want.byte_offset),
                                      16'(seen.byte_offset))
                        + score_field("record_index", want.record_index, seen.record_index)
                        + score_field("record_end", 16'(want.record_end),
                                      16'(seen.record_end))
                        + score_field("record_len", 16'(want.record_len),
                                      16'(seen.record_len))
                        + score_field("done_res", 16'(want.done_res), 16'(seen.done_res))
                        + score_field("status", 16'(want.status), 16'(seen.status))
                        + score_field("record_count", want.record_count, seen.record_count);
                end
            end
            errors  <= fail_count;
            waiting <= expected_q.size();
        end
    end

endmodule

### sim/sector_record_deframer_test.sv
// Test top for the sector record deframer: stimulus, idling and the verdict.
`timescale 1ns / 1ps

module sector_record_deframer_test;
    import sdr_pkg::*;

    localparam logic [1:0] KIND_SPARE  = 2'd3;
    localparam int         ITEM_TARGET = 1950;
    localparam int         QUIET_TAIL  = 250;
    localparam int         CYCLE_LIMIT = 500000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = CFG_VARIABLE_MODE;
    logic [15:0] cfg_data  = '0;
    logic        in_valid  = 1'b0;
    logic [1:0]  kind      = KIND_DATA;
    logic [7:0]  data_byte = '0;
    logic        out_stall = 1'b0;

    logic        in_stall;
    logic        out_valid;
    logic        data_valid;
    logic [7:0]  out_byte;
    logic [7:0]  byte_offset;
    logic [15:0] record_index;
    logic        record_end;
    logic [7:0]  record_len;
    logic        done_res;
    logic [1:0]  status;
    logic [15:0] record_count;
    res_t        seen_res;

    int          errors;
    int          waiting;
    int          stim_count = 0;
    int          cycles     = 0;
    int          stall_left = 0;
    bit          gap_on     = 1'b1;
    bit          stall_on   = 1'b1;

    sector_record_deframer DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .data_valid   (data_valid),
        .out_byte     (out_byte),
        .byte_offset  (byte_offset),
        .record_index (record_index),
        .record_end   (record_end),
        .record_len   (record_len),
        .done_res     (done_res),
        .status       (status),
        .record_count (record_count)
    );

    assign seen_res = {data_valid, out_byte, byte_offset, record_index, record_end,
                       record_len, done_res, status, record_count};

    deframer_scoreboard scoreboard (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .data_byte (data_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .seen      (seen_res),
        .errors    (errors),
        .waiting   (waiting)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Cycle budget
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver back-pressure in bursts of random length
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
            stall_left <= stall_left - 1;
        else if (stall_on && $urandom_range(0, 4) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 4);
        end
        else
            out_stall <= 1'b0;
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // One transfer on the input channel, with an occasional gap before it
    task automatic send_item(input logic [1:0] k, input logic [7:0] b, input bit counted);
        int gap;
        if (gap_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 5);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        kind      <= k;
        data_byte <= b;
        do
            @(posedge clk);
        while (in_stall);
        if (counted)
            stim_count++;
    endtask

    // Hold off until every result is in, plus the block's latency
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (waiting != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(input logic mode, input logic [7:0] len, input logic [15:0] total);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_VARIABLE_MODE;
        cfg_data  <= {15'd0, mode};
        @(posedge clk);
        cfg_index <= CFG_RECORD_LENGTH;
        cfg_data  <= {8'd0, len};
        @(posedge clk);
        cfg_index <= CFG_RECORD_TOTAL;
        cfg_data  <= total;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Fixed-length file: records packed per sector, short tails skipped
    task automatic fixed_file(input logic [7:0] len, input logic [15:0] total);
        int flen;
        int room;
        int recs;
        flen = (len == 0) ? 1 : len;
        room = SECTOR_SIZE;
        recs = (total > 12) ? $urandom_range(0, 6) : total;
        send_item(KIND_START, rand_byte(), 1);
        for (int r = 0; r < recs; r++)
        begin
            if (room < flen)
            begin
                repeat (room) send_item(KIND_DATA, rand_byte(), 1);
                room = SECTOR_SIZE;
            end
            // file cut off inside a record
            if ($urandom_range(0, 15) == 0)
            begin
                repeat ($urandom_range(0, flen - 1)) send_item(KIND_DATA, rand_byte(), 1);
                send_item(KIND_EOF, rand_byte(), 1);
                return;
            end
            repeat (flen) send_item(KIND_DATA, rand_byte(), 1);
            room -= flen;
        end
        if (recs != total)
            send_item(KIND_EOF, rand_byte(), 1);
    endtask

    // Variable-length file: length-prefixed records, each sector closed by a mark
    task automatic variable_file(input int sectors);
        int room;
        int nrec;
        int b;
        int pick;
        send_item(KIND_START, rand_byte(), 1);
        for (int s = 0; s < sectors; s++)
        begin
            room = SECTOR_SIZE;
            nrec = $urandom_range(0, 6);
            for (int r = 0; r < nrec; r++)
            begin
                pick = $urandom_range(0, 23);
                b = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 200) : $urandom_range(0, 24);
                // length running past the end of the sector
                if (pick == 0 && room <= 254)
                begin
                    send_item(KIND_DATA, 8'($urandom_range(room, 254)), 1);
                    return;
                end
                // record filling the sector exactly, then a length byte with no room
                if (pick == 1 && room <= 255)
                begin
                    b = room - 1;
                    send_item(KIND_DATA, 8'(b), 1);
                    repeat (b) send_item(KIND_DATA, rand_byte(), 1);
                    send_item(KIND_DATA, 8'($urandom_range(0, 20)), 1);
                    return;
                end
                if (b + 2 > room)
                    break;
                send_item(KIND_DATA, 8'(b), 1);
                // end of file inside a record
                if (pick == 2)
                begin
                    repeat ($urandom_range(0, b)) send_item(KIND_DATA, rand_byte(), 1);
                    send_item(KIND_EOF, rand_byte(), 1);
                    return;
                end
                repeat (b) send_item(KIND_DATA, rand_byte(), 1);
                room -= b + 1;
            end
            send_item(KIND_DATA, SKIP_MARK, 1);
            room--;
            if (s < sectors - 1)
                repeat (room) send_item(KIND_DATA, rand_byte(), 1);
        end
    endtask

    initial
    begin
        logic        mode;
        logic [7:0]  len;
        logic [15:0] total;
        int          sectors;
        bit          quiet;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: fixed mode, no records, so a data byte finishes at once
        send_item(KIND_DATA, 8'h00, 1);
        send_item(KIND_EOF, 8'hFF, 1);
        send_item(KIND_SPARE, 8'hA5, 1);
        settle();

        // Fixed length zero acts as one; data after done is ignored
        set_config(1'b0, 8'd0, 16'd2);
        send_item(KIND_START, 8'h00, 1);
        send_item(KIND_DATA, 8'h00, 1);
        send_item(KIND_DATA, 8'hFF, 1);
        send_item(KIND_DATA, 8'h3C, 1);
        settle();

        // Start with no records finishes at once
        set_config(1'b0, 8'd1, 16'd0);
        send_item(KIND_START, 8'hFF, 1);
        settle();

        // Record total lowered mid-file: end of file, then a data byte, both complete
        set_config(1'b0, 8'd1, 16'd3);
        send_item(KIND_START, 8'h11, 1);
        send_item(KIND_DATA, 8'h5A, 1);
        settle();
        set_config(1'b0, 8'd1, 16'd1);
        send_item(KIND_EOF, 8'h00, 1);
        settle();
        set_config(1'b0, 8'd1, 16'd3);
        send_item(KIND_START, 8'h22, 1);
        send_item(KIND_DATA, 8'hC3, 1);
        settle();
        set_config(1'b0, 8'd1, 16'd1);
        send_item(KIND_DATA, 8'h99, 1);
        settle();

        // Variable mode: empty record, record cut to length, then truncation
        set_config(1'b1, 8'd3, 16'd1);
        send_item(KIND_START, 8'h00, 1);
        send_item(KIND_DATA, 8'd0, 1);
        send_item(KIND_DATA, 8'd5, 1);
        repeat (5) send_item(KIND_DATA, rand_byte(), 1);
        send_item(KIND_EOF, 8'h00, 1);
        settle();

        // Variable mode with a sector total of zero
        set_config(1'b1, 8'd254, 16'd0);
        send_item(KIND_START, 8'h00, 1);
        send_item(KIND_EOF, 8'h00, 1);

        // Random files, mostly well formed, with noise between them
        while (stim_count < ITEM_TARGET)
        begin
            settle();
            quiet    = stim_count > ITEM_TARGET - QUIET_TAIL;
            gap_on   = !quiet && $urandom_range(0, 3) != 0;
            stall_on = !quiet && $urandom_range(0, 3) != 0;
            mode     = $urandom_range(0, 1);
            case ($urandom_range(0, 19))
                0:       len = 8'd0;
                1:       len = 8'd255;
                2:       len = 8'd254;
                3:       len = 8'd1;
                default: len = 8'($urandom_range(2, 24));
            endcase
            if (mode)
            begin
                sectors = $urandom_range(1, 2);
                case ($urandom_range(0, 9))
                    0:       total = 16'd0;
                    1:       total = 16'hFFFF;
                    2:       total = 16'(sectors + 1);
                    default: total = 16'(sectors);
                endcase
                set_config(mode, len, total);
                variable_file(sectors);
                if (total != sectors)
                    send_item(KIND_EOF, rand_byte(), 1);
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0:       total = 16'd0;
                    1:       total = 16'hFFFF;
                    default: total = 16'($urandom_range(1, (len >= 100) ? 2 : 10));
                endcase
                set_config(mode, len, total);
                fixed_file(len, total);
            end
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 4))
                    send_item(2'($urandom_range(0, 3)), rand_byte(), 1);
        end

        gap_on   = 1'b0;
        stall_on = 1'b0;
        settle();
        if (errors == 0 && waiting == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### filelist.f
design/sdr_pkg.sv
design/sector_record_deframer.sv
sim/deframer_scoreboard.sv
sim/sector_record_deframer_test.sv
